>>> rtl/core/cct_pkg.sv
// cct_pkg: widths, stage indexes, word types and tables of the circle collision test
// no dependencies; used by circle_collision_test
package cct_pkg;

    localparam int COORD_WIDTH  = 32;
    localparam int RAD_WIDTH    = 24;
    localparam int ANG_WIDTH    = 16;
    localparam int ANG_SHIFT    = 17;
    localparam int CORDIC_STEPS = 16;
    localparam int ALPHA_BITS   = 32;
    localparam int ATAN_BITS    = 30;
    localparam int KINV_BITS    = 30;

    localparam int DW   = COORD_WIDTH + 1;
    localparam int PRW  = 2 * COORD_WIDTH;
    localparam int LENW = PRW + 1;
    localparam int REMW = LENW + 1;
    localparam int CXW  = COORD_WIDTH + 2;
    localparam int OXW  = CXW + 1;
    localparam int GW   = OXW + KINV_BITS;
    localparam int XW   = OXW + 3;
    localparam int ZW   = ANG_WIDTH + ANG_SHIFT + 3;
    localparam int QW   = CXW + 1;
    localparam int EW   = XW + 2;
    localparam int D2W  = 2 * EW;
    localparam int SW   = D2W + 1;
    localparam int OFW  = COORD_WIDTH + 1;
    localparam int POW  = COORD_WIDTH + ALPHA_BITS + 1;
    localparam int R2W  = 2 * RAD_WIDTH;
    localparam int RSW  = RAD_WIDTH + 1;
    localparam int RS2W = 2 * RSW;

    localparam logic [KINV_BITS-1:0] KINV    = 30'd652032874;
    localparam logic signed [ZW-1:0] HALF_PI = ZW'(1686629713);

    localparam logic signed [QW-1:0] SAT_HI =
        QW'($signed({1'b0, {(COORD_WIDTH-1){1'b1}}}));
    localparam logic signed [QW-1:0] SAT_LO = -SAT_HI - QW'(1);

    localparam logic [1:0] KIND_SEG  = 2'd0;
    localparam logic [1:0] KIND_BOX  = 2'd1;
    localparam logic [1:0] KIND_CIRC = 2'd2;

    localparam int ST_MUL   = 1;
    localparam int ST_LEN   = 2;
    localparam int MID0     = 3;
    localparam int ST_OFF   = MID0 + ALPHA_BITS;
    localparam int ST_DIFF  = ST_OFF + 1;
    localparam int ST_SQ    = ST_DIFF + 1;
    localparam int ST_OUT   = ST_SQ + 1;
    localparam int N_STAGES = ST_OUT + 1;

    typedef struct packed {
        logic [1:0]                    req_type;
        logic signed [COORD_WIDTH-1:0] ball_x;
        logic signed [COORD_WIDTH-1:0] ball_y;
        logic [RAD_WIDTH-1:0]          ball_radius;
        logic signed [COORD_WIDTH-1:0] shape_x;
        logic signed [COORD_WIDTH-1:0] shape_y;
        logic signed [COORD_WIDTH-1:0] end_x;
        logic signed [COORD_WIDTH-1:0] end_y;
        logic [RAD_WIDTH-1:0]          rect_width;
        logic [RAD_WIDTH-1:0]          rect_height;
        logic signed [ANG_WIDTH-1:0]   rect_angle;
        logic [RAD_WIDTH-1:0]          other_radius;
    } t_in_word;

    typedef struct packed {
        logic                          collided;
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
    } t_out_word;

    typedef struct packed {
        logic [1:0]                    kind;
        logic signed [COORD_WIDTH-1:0] bx;
        logic signed [COORD_WIDTH-1:0] by;
        logic signed [COORD_WIDTH-1:0] sx;
        logic signed [COORD_WIDTH-1:0] sy;
        logic [RAD_WIDTH-1:0]          br;
        logic [RAD_WIDTH-1:0]          rw;
        logic [RAD_WIDTH-1:0]          rh;
        logic [RSW-1:0]                rs;
        logic [RS2W-1:0]               rs2;
        logic [R2W-1:0]                r2;
        logic signed [DW-1:0]          dx;
        logic signed [DW-1:0]          dy;
        logic signed [DW-1:0]          wx;
        logic signed [DW-1:0]          wy;
        logic [PRW-1:0]                m1;
        logic [PRW-1:0]                m2;
        logic                          n1;
        logic                          n2;
        logic [PRW-1:0]                sqa;
        logic [PRW-1:0]                sqb;
        logic [LENW-1:0]               len;
        logic [REMW-1:0]               rem;
        logic                          zl;
        logic                          full;
        logic [ALPHA_BITS-1:0]         alpha;
        logic [OFW-1:0]                ofx;
        logic [OFW-1:0]                ofy;
        logic signed [CXW-1:0]         cx;
        logic signed [CXW-1:0]         cy;
        logic signed [OXW-1:0]         ox;
        logic signed [OXW-1:0]         oy;
        logic [GW-1:0]                 gx;
        logic [GW-1:0]                 gy;
        logic signed [XW-1:0]          x;
        logic signed [XW-1:0]          y;
        logic signed [ZW-1:0]          z;
        logic signed [XW:0]            rx;
        logic signed [XW:0]            ry;
        logic signed [QW-1:0]          qx;
        logic signed [QW-1:0]          qy;
        logic signed [EW-1:0]          ddx;
        logic signed [EW-1:0]          ddy;
        logic [D2W-1:0]                dsa;
        logic [D2W-1:0]                dsb;
        logic                          hit;
        logic signed [COORD_WIDTH-1:0] outx;
        logic signed [COORD_WIDTH-1:0] outy;
    } t_work;

    function automatic logic [ATAN_BITS-1:0] atan_q30(input int k);
        logic [ATAN_BITS-1:0] v;
        case (k)
            0:       v = 30'h3243F6A8;
            1:       v = 30'h1DAC6705;
            2:       v = 30'h0FADBAFC;
            3:       v = 30'h07F56EA6;
            4:       v = 30'h03FEAB76;
            5:       v = 30'h01FFD55B;
            6:       v = 30'h00FFFAAA;
            7:       v = 30'h007FFF55;
            8:       v = 30'h003FFFEA;
            9:       v = 30'h001FFFFD;
            10:      v = 30'h000FFFFF;
            11:      v = 30'h0007FFFF;
            12:      v = 30'h0003FFFF;
            13:      v = 30'h0001FFFF;
            14:      v = 30'h0000FFFF;
            15:      v = 30'h00007FFF;
            16:      v = 30'h00003FFF;
            17:      v = 30'h00001FFF;
            18:      v = 30'h00000FFF;
            19:      v = 30'h000007FF;
            20:      v = 30'h000003FF;
            21:      v = 30'h000001FF;
            22:      v = 30'h000000FF;
            23:      v = 30'h0000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] sat_coord(input logic signed [QW-1:0] v);
        logic signed [QW-1:0] c;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end else begin
            c = v;
        end
        return c[COORD_WIDTH-1:0];
    endfunction

endpackage

>>> rtl/core/circle_collision_test.sv
// circle_collision_test: pipelined circle against segment, rotated box or circle test
// depends on cct_pkg for word types, widths, stage indexes and the arctangent table
//
// usage:
//   input channel i_valid / o_ready carries one request word i_req per handshake;
//   output channel o_valid / i_ready carries one result word o_res per request,
//   in request order.
//   every request passes a fixed chain of N_STAGES (39) register stages, and the
//   last stage drives o_res. one word can enter every cycle while o_ready is high;
//   the length of the chain is set by the one-bit-per-stage divider for the
//   segment projection (32 stages), which the 16 rotation steps of the box test
//   share.
//   each stage has its own valid bit and moves on when the stage after it is empty
//   or moving, so while i_ready is low the block keeps taking words until every
//   stage is full; nothing is dropped or repeated.
//   reset (i_rst_n low at a clock edge) empties all stages; no clearing pass.
module circle_collision_test import cct_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_req,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_res
);

    t_work                r_st [N_STAGES];
    t_work                n_st [N_STAGES];
    logic [N_STAGES-1:0]  r_vld;
    logic [N_STAGES-1:0]  adv;

    function automatic t_work load_fn(input t_in_word q);
        t_work w;
        w         = '0;
        w.kind    = q.req_type;
        w.bx      = q.ball_x;
        w.by      = q.ball_y;
        w.sx      = q.shape_x;
        w.sy      = q.shape_y;
        w.br      = q.ball_radius;
        w.rw      = q.rect_width;
        w.rh      = q.rect_height;
        w.rs      = RSW'(q.ball_radius) + RSW'(q.other_radius);
        w.dx      = DW'(q.end_x) - DW'(q.shape_x);
        w.dy      = DW'(q.end_y) - DW'(q.shape_y);
        w.wx      = DW'(q.ball_x) - DW'(q.shape_x);
        w.wy      = DW'(q.ball_y) - DW'(q.shape_y);
        w.cx      = CXW'(q.shape_x) + CXW'($signed({1'b0, q.rect_width[RAD_WIDTH-1:1]}));
        w.cy      = CXW'(q.shape_y) + CXW'($signed({1'b0, q.rect_height[RAD_WIDTH-1:1]}));
        w.ox      = OXW'(q.ball_x) - OXW'(w.cx);
        w.oy      = OXW'(q.ball_y) - OXW'(w.cy);
        w.z       = -(ZW'(q.rect_angle) <<< ANG_SHIFT);
        return w;
    endfunction

    function automatic t_work stage_fn(input t_work a, input int k);
        t_work                   w;
        logic [COORD_WIDTH-1:0]  mdx;
        logic [COORD_WIDTH-1:0]  mdy;
        logic [COORD_WIDTH-1:0]  mwx;
        logic [COORD_WIDTH-1:0]  mwy;
        logic [COORD_WIDTH-1:0]  sa;
        logic [COORD_WIDTH-1:0]  sb;
        logic [OXW-1:0]          mox;
        logic [OXW-1:0]          moy;
        logic [LENW-1:0]         lenv;
        logic [LENW-1:0]         dotv;
        logic                    neg;
        logic [REMW-1:0]         rem2;
        logic                    sub_ok;
        logic signed [XW-1:0]    xs;
        logic signed [XW-1:0]    ys;
        logic signed [XW-1:0]    tmp;
        logic signed [ZW-1:0]    at;
        logic [ALPHA_BITS:0]     av;
        logic [POW-1:0]          pox;
        logic [POW-1:0]          poy;
        logic signed [CXW-1:0]   hx;
        logic signed [CXW-1:0]   hy;
        logic signed [XW:0]      ix;
        logic signed [XW:0]      iy;
        logic signed [QW-1:0]    offx;
        logic signed [QW-1:0]    offy;
        logic signed [QW-1:0]    psx;
        logic signed [QW-1:0]    psy;
        logic [EW-1:0]           mex;
        logic [EW-1:0]           mey;
        logic [SW-1:0]           ssum;
        int                      j;
        w   = a;
        mdx = COORD_WIDTH'(a.dx < 0 ? -a.dx : a.dx);
        mdy = COORD_WIDTH'(a.dy < 0 ? -a.dy : a.dy);
        mwx = COORD_WIDTH'(a.wx < 0 ? -a.wx : a.wx);
        mwy = COORD_WIDTH'(a.wy < 0 ? -a.wy : a.wy);
        if (k == ST_MUL) begin
            sa    = (a.kind == KIND_CIRC) ? mwx : mdx;
            sb    = (a.kind == KIND_CIRC) ? mwy : mdy;
            w.sqa = PRW'(sa) * PRW'(sa);
            w.sqb = PRW'(sb) * PRW'(sb);
            w.m1  = PRW'(mdx) * PRW'(mwx);
            w.m2  = PRW'(mdy) * PRW'(mwy);
            w.n1  = a.dx[DW-1] ^ a.wx[DW-1];
            w.n2  = a.dy[DW-1] ^ a.wy[DW-1];
            mox   = OXW'(a.ox < 0 ? -a.ox : a.ox);
            moy   = OXW'(a.oy < 0 ? -a.oy : a.oy);
            w.gx  = GW'(mox) * GW'(KINV);
            w.gy  = GW'(moy) * GW'(KINV);
            w.r2  = R2W'(a.br) * R2W'(a.br);
            w.rs2 = RS2W'(a.rs) * RS2W'(a.rs);
        end else if (k == ST_LEN) begin
            lenv  = LENW'(a.sqa) + LENW'(a.sqb);
            w.hit = (a.kind == KIND_CIRC) && (lenv <= LENW'(a.rs2));
            if (a.n1 == a.n2) begin
                dotv = LENW'(a.m1) + LENW'(a.m2);
                neg  = a.n1;
            end else if (a.m2 <= a.m1) begin
                dotv = LENW'(a.m1) - LENW'(a.m2);
                neg  = a.n1;
            end else begin
                dotv = LENW'(a.m2) - LENW'(a.m1);
                neg  = a.n2;
            end
            if (neg) begin
                dotv = '0;
            end else if (lenv <= dotv) begin
                dotv = lenv;
            end
            w.len  = lenv;
            w.rem  = REMW'(dotv);
            w.zl   = (lenv == '0);
            w.full = (dotv == lenv);
            w.alpha = '0;
            // gain correction, truncated toward zero
            tmp = $signed(XW'(a.gx[GW-1:KINV_BITS]));
            w.x = (a.ox < 0) ? -tmp : tmp;
            tmp = $signed(XW'(a.gy[GW-1:KINV_BITS]));
            w.y = (a.oy < 0) ? -tmp : tmp;
            // quarter turns into the convergence range
            for (j = 0; j < 2; j++) begin
                if (w.z > HALF_PI) begin
                    tmp = w.x;
                    w.x = -w.y;
                    w.y = tmp;
                    w.z = w.z - HALF_PI;
                end else if (w.z < -HALF_PI) begin
                    tmp = w.x;
                    w.x = w.y;
                    w.y = -tmp;
                    w.z = w.z + HALF_PI;
                end
            end
        end else if (k >= MID0 && k < ST_OFF) begin
            j      = k - MID0;
            // one quotient bit of the projection
            rem2   = {a.rem[REMW-2:0], 1'b0};
            sub_ok = (rem2 >= REMW'(a.len));
            w.rem  = sub_ok ? rem2 - REMW'(a.len) : rem2;
            w.alpha = {a.alpha[ALPHA_BITS-2:0], sub_ok};
            // one rotation step
            if (j < CORDIC_STEPS) begin
                xs = a.x >>> j;
                ys = a.y >>> j;
                at = ZW'(atan_q30(j));
                if (a.z >= 0) begin
                    w.x = a.x - ys;
                    w.y = a.y + xs;
                    w.z = a.z - at;
                end else begin
                    w.x = a.x + ys;
                    w.y = a.y - xs;
                    w.z = a.z + at;
                end
            end
        end else if (k == ST_OFF) begin
            if (a.zl) begin
                av = '0;
            end else if (a.full) begin
                av = {1'b1, {ALPHA_BITS{1'b0}}};
            end else begin
                av = {1'b0, a.alpha};
            end
            pox   = POW'(mdx) * POW'(av);
            poy   = POW'(mdy) * POW'(av);
            w.ofx = pox[POW-1:ALPHA_BITS];
            w.ofy = poy[POW-1:ALPHA_BITS];
            w.rx  = (XW+1)'(a.x) + (XW+1)'(a.cx);
            w.ry  = (XW+1)'(a.y) + (XW+1)'(a.cy);
        end else if (k == ST_DIFF) begin
            offx = QW'($signed({1'b0, a.ofx}));
            offy = QW'($signed({1'b0, a.ofy}));
            if (a.dx < 0) begin
                offx = -offx;
            end
            if (a.dy < 0) begin
                offy = -offy;
            end
            psx = QW'(a.sx) + offx;
            psy = QW'(a.sy) + offy;
            hx  = CXW'(a.sx) + CXW'($signed({1'b0, a.rw}));
            hy  = CXW'(a.sy) + CXW'($signed({1'b0, a.rh}));
            if (a.rx < (XW+1)'(a.sx)) begin
                ix = (XW+1)'(a.sx);
            end else if (a.rx > (XW+1)'(hx)) begin
                ix = (XW+1)'(hx);
            end else begin
                ix = a.rx;
            end
            if (a.ry < (XW+1)'(a.sy)) begin
                iy = (XW+1)'(a.sy);
            end else if (a.ry > (XW+1)'(hy)) begin
                iy = (XW+1)'(hy);
            end else begin
                iy = a.ry;
            end
            if (a.kind == KIND_SEG) begin
                w.qx  = psx;
                w.qy  = psy;
                w.ddx = EW'(psx) - EW'(a.bx);
                w.ddy = EW'(psy) - EW'(a.by);
            end else begin
                w.qx  = QW'(ix);
                w.qy  = QW'(iy);
                w.ddx = EW'(a.rx) - EW'(ix);
                w.ddy = EW'(a.ry) - EW'(iy);
            end
        end else if (k == ST_SQ) begin
            mex   = EW'(a.ddx < 0 ? -a.ddx : a.ddx);
            mey   = EW'(a.ddy < 0 ? -a.ddy : a.ddy);
            // a distance past the largest radius never hits, so the squares stay narrow
            if (mex[EW-1:RAD_WIDTH] != '0) begin
                mex = EW'(1) << RAD_WIDTH;
            end
            if (mey[EW-1:RAD_WIDTH] != '0) begin
                mey = EW'(1) << RAD_WIDTH;
            end
            w.dsa = D2W'(mex[RAD_WIDTH:0]) * D2W'(mex[RAD_WIDTH:0]);
            w.dsb = D2W'(mey[RAD_WIDTH:0]) * D2W'(mey[RAD_WIDTH:0]);
        end else if (k == ST_OUT) begin
            ssum = SW'(a.dsa) + SW'(a.dsb);
            if (a.kind == KIND_SEG || a.kind == KIND_BOX) begin
                w.hit  = (ssum <= SW'(a.r2));
                w.outx = sat_coord(a.qx);
                w.outy = sat_coord(a.qy);
            end else begin
                w.outx = '0;
                w.outy = '0;
            end
        end
        return w;
    endfunction

    always_comb begin
        n_st[0] = load_fn(i_req);
    end

    for (genvar g = 1; g < N_STAGES; g++) begin : g_stage
        always_comb begin
            n_st[g] = stage_fn(r_st[g-1], g);
        end
    end

    always_comb begin
        adv[N_STAGES-1] = !r_vld[N_STAGES-1] || i_ready;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < N_STAGES; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= (k == 0) ? i_valid : r_vld[k-1];
                end
            end
        end
    end

    for (genvar g = 0; g < N_STAGES; g++) begin : g_reg
        always_ff @(posedge i_clk) begin
            if (adv[g]) begin
                r_st[g] <= n_st[g];
            end
        end
    end

    assign o_ready        = adv[0];
    assign o_valid        = r_vld[N_STAGES-1];
    assign o_res.collided = r_st[N_STAGES-1].hit;
    assign o_res.point_x  = r_st[N_STAGES-1].outx;
    assign o_res.point_y  = r_st[N_STAGES-1].outy;

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for circle_collision_test, directed table then random words
// depends on cct_pkg and circle_collision_test; the contact predictor is local to this file
module testbench;
    import cct_pkg::*;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        t_in_word  req;
        bit        typed;
        t_out_word res;
    } t_row;

    localparam int     CYCLE_LIMIT = 400000;
    localparam int     HOLD_CYCLES = 300;
    localparam int     RAND_PER_PHASE = 100;
    localparam longint KINV_Q30 = 652032874;
    localparam longint QUARTER_Q30 = 1686629713;
    localparam longint ATAN_TBL [24] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
        64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
        64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_HOLD} t_phase;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      i_ready = 1'b0;
    t_in_word  i_req = '0;
    logic      o_ready;
    logic      o_valid;
    t_out_word o_res;

    t_phase    phase = PH_FREE;
    t_out_word pending_contacts [$];
    t_row      rows [$];
    int        failures = 0;
    int        cycles = 0;

    circle_collision_test dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (o_res)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_wide sq_sum(t_wide a, t_wide b);
        return a * a + b * b;
    endfunction

    // |v| * m >> sh, sign put back (truncation toward zero)
    function automatic t_wide scale_trunc(t_wide v, t_wide m, int sh);
        t_wide p;
        p = ((v < 0) ? -v : v) * m;
        p = p >>> sh;
        return (v < 0) ? -p : p;
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] clip_coord(t_wide v);
        t_wide hi, lo;
        hi = 128'sd2147483647;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[COORD_WIDTH-1:0];
    endfunction

    function automatic t_out_word predict_contact(t_in_word w);
        t_out_word o;
        t_wide bx, by, sx, sy, ex, ey, rw, rh, r2, rs;
        t_wide dx, dy, wx, wy, len, dot, alpha, px, py;
        t_wide cx, cy, x, y, z, t, xs, ys, rx, ry, ix, iy;
        bx = t_wide'(w.ball_x);
        by = t_wide'(w.ball_y);
        sx = t_wide'(w.shape_x);
        sy = t_wide'(w.shape_y);
        ex = t_wide'(w.end_x);
        ey = t_wide'(w.end_y);
        rw = t_wide'(w.rect_width);
        rh = t_wide'(w.rect_height);
        r2 = t_wide'(w.ball_radius) * t_wide'(w.ball_radius);
        o = '0;
        case (w.req_type)
            KIND_SEG: begin
                dx = ex - sx;
                dy = ey - sy;
                wx = bx - sx;
                wy = by - sy;
                len = sq_sum(dx, dy);
                dot = dx * wx + dy * wy;
                if (dot < 0) dot = 0;
                else if (dot >= len) dot = len;
                if (len == 0) alpha = 0;
                else if (dot == len) alpha = t_wide'(1) <<< 32;
                else alpha = (dot <<< 32) / len;
                px = sx + scale_trunc(dx, alpha, 32);
                py = sy + scale_trunc(dy, alpha, 32);
                o.collided = (sq_sum(px - bx, py - by) <= r2);
                o.point_x = clip_coord(px);
                o.point_y = clip_coord(py);
            end
            KIND_BOX: begin
                cx = sx + (rw >>> 1);
                cy = sy + (rh >>> 1);
                x = scale_trunc(bx - cx, KINV_Q30, 30);
                y = scale_trunc(by - cy, KINV_Q30, 30);
                z = -t_wide'(w.rect_angle) * 131072;
                for (int i = 0; i < 2; i++) begin
                    if (z > QUARTER_Q30) begin
                        t = x; x = -y; y = t; z = z - QUARTER_Q30;
                    end else if (z < -QUARTER_Q30) begin
                        t = x; x = y; y = -t; z = z + QUARTER_Q30;
                    end
                end
                for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
                    xs = x >>> i;
                    ys = y >>> i;
                    if (z >= 0) begin
                        x = x - ys; y = y + xs; z = z - ATAN_TBL[i];
                    end else begin
                        x = x + ys; y = y - xs; z = z + ATAN_TBL[i];
                    end
                end
                rx = x + cx;
                ry = y + cy;
                ix = (rx < sx) ? sx : ((rx > sx + rw) ? sx + rw : rx);
                iy = (ry < sy) ? sy : ((ry > sy + rh) ? sy + rh : ry);
                o.collided = (sq_sum(rx - ix, ry - iy) <= r2);
                o.point_x = clip_coord(ix);
                o.point_y = clip_coord(iy);
            end
            KIND_CIRC: begin
                rs = t_wide'(w.ball_radius) + t_wide'(w.other_radius);
                o.collided = (sq_sum(bx - sx, by - sy) <= rs * rs);
            end
            default: o = '0;
        endcase
        return o;
    endfunction

    function automatic t_in_word make_req(logic [1:0] k, int bx, int by, int br, int sx,
                                          int sy, int ex, int ey, int rw, int rh,
                                          int ang, int orad);
        t_in_word w;
        w.req_type = k;
        w.ball_x = bx;
        w.ball_y = by;
        w.ball_radius = RAD_WIDTH'(br);
        w.shape_x = sx;
        w.shape_y = sy;
        w.end_x = ex;
        w.end_y = ey;
        w.rect_width = RAD_WIDTH'(rw);
        w.rect_height = RAD_WIDTH'(rh);
        w.rect_angle = ANG_WIDTH'(ang);
        w.other_radius = RAD_WIDTH'(orad);
        return w;
    endfunction

    function automatic void add_row(t_in_word w, bit typed, t_out_word r);
        t_row row;
        row.req = w;
        row.typed = typed;
        row.res = r;
        rows = {rows, row};
    endfunction

    function automatic int rand_coord();
        if ($urandom_range(0, 4) == 0) return int'($urandom);
        return int'($urandom_range(0, 131071)) - 65536;
    endfunction

    function automatic int rand_size();
        if ($urandom_range(0, 5) == 0) return int'($urandom_range(0, 24'hFFFFFF));
        return int'($urandom_range(0, 20000));
    endfunction

    function automatic t_in_word rand_req();
        t_in_word w;
        int sel, sx, sy;
        sel = $urandom_range(0, 15);
        sx = rand_coord();
        sy = rand_coord();
        w = make_req(2'd0, sx + int'($urandom_range(0, 20000)) - 10000,
                     sy + int'($urandom_range(0, 20000)) - 10000, rand_size(), sx, sy,
                     sx + int'($urandom_range(0, 40000)) - 20000,
                     sy + int'($urandom_range(0, 40000)) - 20000, rand_size(), rand_size(),
                     int'($urandom_range(0, 51472)) - 25736, rand_size());
        if (sel < 5) w.req_type = KIND_SEG;
        else if (sel < 10) w.req_type = KIND_BOX;
        else if (sel < 15) w.req_type = KIND_CIRC;
        else w.req_type = 2'd3;
        if ($urandom_range(0, 9) == 0) w.ball_x = rand_coord();
        if ($urandom_range(0, 9) == 0) w.ball_y = rand_coord();
        if ($urandom_range(0, 9) == 0) w.end_x = $urandom;
        if ($urandom_range(0, 9) == 0) w.end_y = $urandom;
        if ($urandom_range(0, 15) == 0)
            w.rect_angle = ANG_WIDTH'($urandom_range(0, 1) ? 25736 : -25736);
        return w;
    endfunction

    function automatic bit idle_now(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    task automatic send_word(t_in_word w, t_out_word res);
        int pct;
        pct = (phase == PH_SEND_IDLE) ? 56 : ((phase == PH_BOTH) ? 7 : 0);
        if (idle_now(pct)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while (idle_now(pct)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req <= w;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_contacts = {pending_contacts, res};
    endtask

    // receive side, long hold-off once in the pressure phase
    initial begin
        bit held;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (phase == PH_HOLD && !held) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                held = 1'b1;
            end
            case (phase)
                PH_RECV_STALL: i_ready <= !idle_now(56);
                PH_BOTH:       i_ready <= !idle_now(7);
                default:       i_ready <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_contacts.size() == 0) begin
                $error("result word with no request waiting");
                failures++;
            end else begin
                want = pending_contacts.pop_front();
                if (o_res.collided !== want.collided) begin
                    $error("collided: expected %0d got %0d", want.collided, o_res.collided);
                    failures++;
                end
                if (o_res.point_x !== want.point_x) begin
                    $error("point_x: expected %0d got %0d", want.point_x, o_res.point_x);
                    failures++;
                end
                if (o_res.point_y !== want.point_y) begin
                    $error("point_y: expected %0d got %0d", want.point_y, o_res.point_y);
                    failures++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("circle_collision_test: mismatch");
            $finish;
        end
    end

    initial begin
        t_out_word hit_none, hit_zero_seg, far_zero_seg, circ_touch;
        t_in_word w;
        hit_none = '0;
        circ_touch = '0;
        circ_touch.collided = 1'b1;
        hit_zero_seg = '{collided: 1'b1, point_x: 1000, point_y: -2000};
        far_zero_seg = '{collided: 1'b0, point_x: 1000, point_y: -2000};

        add_row(make_req(KIND_CIRC, 0, 0, 256, 512, 0, 0, 0, 0, 0, 0, 256), 1, circ_touch);
        add_row(make_req(KIND_CIRC, 0, 0, 256, 513, 0, 0, 0, 0, 0, 0, 256), 1, hit_none);
        add_row(make_req(KIND_CIRC, 32'h80000000, 32'h80000000, 24'hFFFFFF, 32'h7FFFFFFF,
                         32'h7FFFFFFF, 0, 0, 0, 0, 0, 24'hFFFFFF), 1, hit_none);
        add_row(make_req(2'd3, -1, -1, 24'hFFFFFF, -1, -1, -1, -1, 24'hFFFFFF, 24'hFFFFFF,
                         -1, 24'hFFFFFF), 1, hit_none);
        add_row(make_req(KIND_SEG, 1000, -2000, 0, 1000, -2000, 1000, -2000, 0, 0, 0, 0),
                1, hit_zero_seg);
        add_row(make_req(KIND_SEG, 0, 0, 10, 1000, -2000, 1000, -2000, 0, 0, 0, 0),
                1, far_zero_seg);
        add_row(make_req(KIND_SEG, 1280, 300, 400, 0, 0, 2560, 0, 0, 0, 0, 0), 0, hit_none);
        add_row(make_req(KIND_SEG, -900, 50, 1000, 0, 0, 2560, 700, 0, 0, 0, 0), 0, hit_none);
        add_row(make_req(KIND_SEG, 9000, 50, 300, 0, 0, 2560, 700, 0, 0, 0, 0), 0, hit_none);
        add_row(make_req(KIND_SEG, 0, 0, 24'hFFFFFF, 32'h80000000, 32'h80000000,
                         32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 0), 0, hit_none);
        add_row(make_req(KIND_SEG, 32'h7FFFFFFF, 32'h80000000, 5, 32'h80000000,
                         32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 0), 0, hit_none);
        add_row(make_req(KIND_BOX, 500, 500, 100, 0, 0, 0, 0, 1024, 512, 0, 0), 0, hit_none);
        add_row(make_req(KIND_BOX, 3000, -800, 900, 0, 0, 0, 0, 1024, 512, 25736, 0),
                0, hit_none);
        add_row(make_req(KIND_BOX, 3000, -800, 900, 0, 0, 0, 0, 1024, 512, -25736, 0),
                0, hit_none);
        add_row(make_req(KIND_BOX, -700, 1800, 600, 0, 0, 0, 0, 2048, 256, 12868, 0),
                0, hit_none);
        add_row(make_req(KIND_BOX, -700, 1800, 600, 0, 0, 0, 0, 2048, 256, -12868, 0),
                0, hit_none);
        add_row(make_req(KIND_BOX, 32'h80000000, 32'h80000000, 24'hFFFFFF, 32'h7FFFFFFF,
                         32'h7FFFFFFF, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 3000, 0), 0, hit_none);
        add_row(make_req(KIND_BOX, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 32'h80000000,
                         32'h80000000, 0, 0, 0, 0, -9000, 0), 0, hit_none);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i])
            send_word(rows[i].req, rows[i].typed ? rows[i].res : predict_contact(rows[i].req));

        for (int p = PH_FREE; p <= PH_HOLD; p++) begin
            phase = t_phase'(p);
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                w = rand_req();
                send_word(w, predict_contact(w));
            end
        end
        i_valid <= 1'b0;
        phase = PH_FREE;

        while (pending_contacts.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (failures == 0 && pending_contacts.size() == 0) begin
            $display("circle_collision_test: match");
        end else begin
            $display("circle_collision_test: mismatch");
        end
        $finish;
    end

endmodule
